>>> design/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and constants of the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_QUOTE = 2'd0;
    localparam logic [1:0] ERR_END   = 2'd1;
    localparam logic [1:0] ERR_HEX   = 2'd2;
    localparam logic [1:0] ERR_ESC   = 2'd3;

    // characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } result_t;

    // one queued job: up to three result words of the same kind
    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      error_code;
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
    } job_t;

endpackage

>>> design/jsu_front.sv
// ---------------------------------------------------------------------------
// jsu_front
// Scanner: tracks string/escape/hex mode and turns each accepted byte into
// at most one job for the back end.
// ---------------------------------------------------------------------------
module jsu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  jsu_pkg::item_t item,
    output logic           job_valid,
    output jsu_pkg::job_t  job
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [1:0]     hex_left_reg, hex_left_next;
    logic [15:0]    code_reg, code_next;

    logic [7:0]  c;
    logic        eoi;
    logic        is_ws;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic [15:0] cp;

    always_comb
    begin
        c   = item.in_byte;
        eoi = item.end_of_input;
        is_ws = (c == jsu_pkg::CH_SPACE) || (c == jsu_pkg::CH_TAB) ||
                (c == jsu_pkg::CH_LF) || (c == jsu_pkg::CH_CR);
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            hex_d = c[3:0];
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            hex_d = c[3:0] + 4'd9;
        else
            hex_ok = 1'b0;
        esc_ok   = 1'b1;
        esc_byte = c;
        unique case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: esc_byte = c;
            jsu_pkg::CH_N: esc_byte = jsu_pkg::CH_LF;
            jsu_pkg::CH_R: esc_byte = jsu_pkg::CH_CR;
            jsu_pkg::CH_T: esc_byte = jsu_pkg::CH_TAB;
            jsu_pkg::CH_B: esc_byte = jsu_pkg::CH_BS;
            jsu_pkg::CH_F: esc_byte = jsu_pkg::CH_FF;
            default:       esc_ok   = 1'b0;
        endcase
        cp = {code_reg[11:0], hex_d};
    end

    // next state
    always_comb
    begin
        mode_next     = mode_reg;
        hex_left_next = hex_left_reg;
        code_next     = code_reg;
        if (accept)
        begin
            unique case (mode_reg)
                jsu_pkg::MODE_IDLE:
                begin
                    if (!eoi && c == jsu_pkg::CH_QUOTE)
                        mode_next = jsu_pkg::MODE_STR;
                end
                jsu_pkg::MODE_STR:
                begin
                    priority if (eoi || c == jsu_pkg::CH_QUOTE)
                        mode_next = jsu_pkg::MODE_IDLE;
                    else if (c == jsu_pkg::CH_BSL)
                        mode_next = jsu_pkg::MODE_ESC;
                end
                jsu_pkg::MODE_ESC:
                begin
                    priority if (eoi)
                        mode_next = jsu_pkg::MODE_IDLE;
                    else if (c == jsu_pkg::CH_U)
                    begin
                        mode_next     = jsu_pkg::MODE_HEX;
                        hex_left_next = 2'd3;
                        code_next     = 16'd0;
                    end
                    else if (esc_ok)
                        mode_next = jsu_pkg::MODE_STR;
                    else
                        mode_next = jsu_pkg::MODE_IDLE;
                end
                jsu_pkg::MODE_HEX:
                begin
                    priority if (eoi || !hex_ok)
                    begin
                        mode_next     = jsu_pkg::MODE_IDLE;
                        hex_left_next = 2'd0;
                        code_next     = 16'd0;
                    end
                    else if (hex_left_reg != 2'd0)
                    begin
                        hex_left_next = hex_left_reg - 2'd1;
                        code_next     = cp;
                    end
                    else
                    begin
                        mode_next = jsu_pkg::MODE_STR;
                        code_next = 16'd0;
                    end
                end
                default: mode_next = jsu_pkg::MODE_IDLE;
            endcase
        end
    end

    // job output
    always_comb
    begin
        job_valid      = 1'b0;
        job.kind       = jsu_pkg::KIND_DATA;
        job.error_code = jsu_pkg::ERR_QUOTE;
        job.count      = 2'd1;
        job.bytes      = '0;
        unique case (mode_reg)
            jsu_pkg::MODE_IDLE:
            begin
                if (eoi || (!is_ws && c != jsu_pkg::CH_QUOTE))
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_QUOTE;
                end
            end
            jsu_pkg::MODE_STR:
            begin
                priority if (eoi)
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_END;
                end
                else if (c == jsu_pkg::CH_QUOTE)
                begin
                    job_valid = 1'b1;
                    job.kind  = jsu_pkg::KIND_DONE;
                end
                else if (c != jsu_pkg::CH_BSL)
                begin
                    job_valid    = 1'b1;
                    job.bytes[0] = c;
                end
            end
            jsu_pkg::MODE_ESC:
            begin
                priority if (eoi)
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_END;
                end
                else if (c == jsu_pkg::CH_U)
                    job_valid = 1'b0;
                else if (esc_ok)
                begin
                    job_valid    = 1'b1;
                    job.bytes[0] = esc_byte;
                end
                else
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_ESC;
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                priority if (eoi)
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_END;
                end
                else if (!hex_ok)
                begin
                    job_valid      = 1'b1;
                    job.kind       = jsu_pkg::KIND_ERR;
                    job.error_code = jsu_pkg::ERR_HEX;
                end
                else if (hex_left_reg == 2'd0)
                begin
                    job_valid = 1'b1;
                    // UTF-8 encoding of the 16-bit code
                    priority if (cp[15:7] == 9'd0)
                    begin
                        job.count    = 2'd1;
                        job.bytes[0] = {1'b0, cp[6:0]};
                    end
                    else if (cp[15:11] == 5'd0)
                    begin
                        job.count    = 2'd2;
                        job.bytes[0] = {3'b110, cp[10:6]};
                        job.bytes[1] = {2'b10, cp[5:0]};
                    end
                    else
                    begin
                        job.count    = 2'd3;
                        job.bytes[0] = {4'b1110, cp[15:12]};
                        job.bytes[1] = {2'b10, cp[11:6]};
                        job.bytes[2] = {2'b10, cp[5:0]};
                    end
                end
            end
            default: job_valid = 1'b0;
        endcase
        job_valid = job_valid && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= jsu_pkg::MODE_IDLE;
            hex_left_reg <= 2'd0;
            code_reg     <= 16'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            hex_left_reg <= hex_left_next;
            code_reg     <= code_next;
        end
    end

endmodule

>>> design/jsu_queue.sv
// ---------------------------------------------------------------------------
// jsu_queue
// Short job queue between scanner and result sequencer.
// ---------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  jsu_pkg::job_t wr_data,
    input  logic          rd_en,
    output jsu_pkg::job_t rd_data,
    output logic          not_empty,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/jsu_back.sv
// ---------------------------------------------------------------------------
// jsu_back
// Result sequencer: expands each queued job into one to three result words
// and holds the oldest one in the output register.
// ---------------------------------------------------------------------------
module jsu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  jsu_pkg::job_t    job,
    output logic             job_pop,
    input  logic             pop,
    output logic             empty,
    output jsu_pkg::result_t result
);

    logic             out_valid_reg, out_valid_next;
    jsu_pkg::result_t out_reg, out_next;
    logic [1:0]       idx_reg, idx_next;
    logic             load;
    logic             final_word;

    assign empty      = !out_valid_reg;
    assign result     = out_reg;
    assign load       = job_valid && (!out_valid_reg || pop);
    assign final_word = (idx_reg == job.count - 2'd1);
    assign job_pop    = load && final_word;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next      = 1'b1;
            out_next.out_byte   = job.bytes[idx_reg];
            out_next.kind       = job.kind;
            out_next.error_code = job.error_code;
            out_next.last       = final_word;
            idx_next            = final_word ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

>>> design/json_string_unescaper_unit.sv
// ---------------------------------------------------------------------------
// json_string_unescaper_unit
// Decodes a JSON string literal from a byte stream into raw / UTF-8 bytes.
// ---------------------------------------------------------------------------
// Input side is a queue: a word (item) goes in when push is high and full is
// low. Result side is a queue too: the oldest result word sits on result
// while empty is low and leaves when pop is high.
// Each input word yields zero to three result words: none for whitespace
// before the string, the opening quote, a backslash or non-final hex digits,
// three at most for the last digit of a \u escape.
// The first result word of an input is queued when that input is taken and
// reaches result through the output register, provided that register is free.
// Throughput: one input word per cycle while full is low; the result register
// drains one word per cycle while pop is high, so a multi-byte \u escape holds
// the input side back only once the job queue (QUEUE_DEPTH entries) has filled.
// A stalled receiver fills the result register, then the job queue, after
// which full rises. Reset returns the scanner to idle and empties the queue
// and result register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module json_string_unescaper_unit #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  jsu_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output jsu_pkg::result_t result
);

    logic          accept;
    logic          fe_job_valid;
    jsu_pkg::job_t fe_job;
    logic          q_not_empty;
    jsu_pkg::job_t q_job;
    logic          q_pop;

    assign accept = push && !full;

    jsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job_valid (fe_job_valid),
        .job       (fe_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (fe_job_valid),
        .wr_data   (fe_job),
        .rd_en     (q_pop),
        .rd_data   (q_job),
        .not_empty (q_not_empty),
        .full      (full)
    );

    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (q_job),
        .job_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> design/jsu_checker.sv
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the unescaper's result channel.
// ---------------------------------------------------------------------------
module jsu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input jsu_pkg::result_t result
);

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.kind == jsu_pkg::KIND_DATA ||
                    result.kind == jsu_pkg::KIND_DONE ||
                    result.kind == jsu_pkg::KIND_ERR))
        else $error("result kind out of range");

    // string end and errors are single words with a zero byte
    a_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind != jsu_pkg::KIND_DATA) |->
            (result.last && result.out_byte == 8'h00))
        else $error("control word malformed");

    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == jsu_pkg::KIND_DATA) |->
            (result.error_code == jsu_pkg::ERR_QUOTE))
        else $error("data word carries an error code");

    // a UTF-8 lead byte is never the last word of its input
    a_lead: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.kind == jsu_pkg::KIND_DATA && result.last &&
         $past(!empty && pop && result.kind == jsu_pkg::KIND_DATA && !result.last)) |->
            (result.out_byte[7:6] == 2'b10))
        else $error("multi-byte sequence ended on a non-continuation byte");

endmodule

bind json_string_unescaper_unit jsu_checker u_jsu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
